FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication check on the rising clock edge, off during reset
`define CHK_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication check
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: hdl/bba_pkg.sv
package bba_pkg;
  localparam int MAX_BLOCKS = 4096;
  localparam int IDX_W = 12;
  localparam int CNT_W = 13;
  localparam int SCAN_BITS = 8;
  localparam int SCAN_LG = $clog2(SCAN_BITS);
  localparam int DEF_WORD_BITS = 64;

  typedef enum logic [1:0] {
    MODE_INIT = 2'd0,
    MODE_LOW  = 2'd1,
    MODE_HIGH = 2'd2,
    MODE_FREE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO_LEN = 3'd1,
    ST_FEW_FREE = 3'd2,
    ST_NO_FIT   = 3'd3,
    ST_RANGE    = 3'd4,
    ST_DBL_FREE = 3'd5,
    ST_BAD_CFG  = 3'd6
  } status_t;

  typedef enum logic {
    REG_BLOCK_COUNT = 1'b0,
    REG_RESERVED    = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_SC_RD,
    S_SC_CHK,
    S_CK_RD,
    S_CK_CMP,
    S_WR_RD,
    S_WR_WR
  } fsm_t;

  typedef struct packed {
    mode_t             mode;
    logic [IDX_W-1:0]  start_block;
    logic [CNT_W-1:0]  run_length;
  } in_t;

  typedef struct packed {
    status_t           status;
    logic [IDX_W-1:0]  block_index;
    logic [CNT_W-1:0]  free_count;
  } out_t;

  typedef struct packed {
    logic [CNT_W-1:0]  pos;
    logic [CNT_W-1:0]  lim;
    logic              asc;
    logic [CNT_W-1:0]  len;
    logic [CNT_W-1:0]  run;
    logic [IDX_W-1:0]  bot;
  } scan_req_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  first;
    logic [CNT_W-1:0]  run;
    logic [IDX_W-1:0]  bot;
  } scan_rsp_t;
endpackage

FILE: hdl/bba_chunk.sv
module bba_chunk #(
  parameter int WORD_BITS = 64
) (
  input  logic [WORD_BITS-1:0] word,
  input  bba_pkg::scan_req_t   req,
  output bba_pkg::scan_rsp_t   rsp
);
  import bba_pkg::*;

  localparam int WB_LG = $clog2(WORD_BITS);

  logic [CNT_W-1:0] b;
  logic             ok;
  logic [CNT_W-1:0] run;
  logic [IDX_W-1:0] bot;
  logic             found;
  logic [IDX_W-1:0] first;

  // one aligned chunk of SCAN_BITS blocks per cycle, never crossing a word
  always_comb begin
    run   = req.run;
    bot   = req.bot;
    found = 1'b0;
    first = '0;
    for (int k = 0; k < SCAN_BITS; k++) begin
      if (req.asc) begin
        b  = {req.pos[CNT_W-1:SCAN_LG], SCAN_LG'(0)} + CNT_W'(k);
        ok = (b >= req.pos) && (b < req.lim);
      end else begin
        b  = {req.pos[CNT_W-1:SCAN_LG], SCAN_LG'(SCAN_BITS-1)} - CNT_W'(k);
        ok = (b <= req.pos);
      end
      if (ok && !found) begin
        if (word[b[WB_LG-1:0]]) begin
          run = '0;
        end else begin
          if (run == '0) begin
            bot = b[IDX_W-1:0];
          end
          run = run + 1'b1;
          if (run == req.len) begin
            found = 1'b1;
            first = req.asc ? bot : b[IDX_W-1:0];
          end
        end
      end
    end
    rsp = '{found: found, first: first, run: run, bot: bot};
  end
endmodule

FILE: hdl/bitmap_block_allocator.sv
// Bad config, zero length, too few free and out of range are answered straight from idle.
// Init writes every map word in turn. Free reads and checks each word, then reads and clears each.
// Reserve scans a chunk of 8 blocks per cycle, with a read state for each map word it enters,
//   then reads and marks each word of the run.
// One request at a time, the next taken in its result cycle; no output stall.
// Synchronous reset; the map reads as clear until the first init.
module bitmap_block_allocator #(
  parameter int WORD_BITS = bba_pkg::DEF_WORD_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  bba_pkg::in_t             in_data,
  output logic                     out_valid,
  output bba_pkg::out_t            out_data,
  input  logic                     cfg_we,
  input  bba_pkg::reg_idx_t        cfg_idx,
  input  logic [bba_pkg::CNT_W-1:0] cfg_wdata
);
  import bba_pkg::*;

  localparam int WB_LG = $clog2(WORD_BITS);
  localparam int MAP_WORDS = MAX_BLOCKS / WORD_BITS;
  localparam int AW = IDX_W - WB_LG;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata_r;
  logic                 rd_en, wr_en;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  fsm_t             st_r, st_nxt;
  mode_t            op_r, op_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [IDX_W-1:0] start_r, start_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] lim_r, lim_nxt;
  logic [CNT_W-1:0] run_r, run_nxt;
  logic [IDX_W-1:0] bot_r, bot_nxt;
  logic             phase_r, phase_nxt;
  logic [AW-1:0]    w_r, w_nxt;
  logic [AW-1:0]    wend_r, wend_nxt;
  logic [IDX_W-1:0] first_r, first_nxt;
  logic [IDX_W-1:0] last_r, last_nxt;
  logic [CNT_W-1:0] free_r, free_nxt;
  logic [IDX_W-1:0] nf_r, nf_nxt;
  logic             inited_r, inited_nxt;
  out_t             out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] bc_r;
  logic [IDX_W-1:0] rb_r;

  logic [WORD_BITS-1:0] word_eff, mask, init_word;
  logic [IDX_W-1:0]     wbase;
  scan_req_t            sreq;
  scan_rsp_t            srsp;
  logic                 bad_cfg;
  logic [IDX_W-1:0]     scan_s;
  logic [CNT_W-1:0]     pos_adv, sum_fl;
  logic                 scan_end;

  bba_chunk #(.WORD_BITS(WORD_BITS)) u_chunk (
    .word (word_eff),
    .req  (sreq),
    .rsp  (srsp)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r <= CNT_W'(MAX_BLOCKS);
      rb_r <= IDX_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_BLOCK_COUNT: bc_r <= cfg_wdata;
        REG_RESERVED:    rb_r <= cfg_wdata[IDX_W-1:0];
        default:         bc_r <= bc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      free_r      <= '0;
      nf_r        <= '0;
      inited_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      free_r      <= free_nxt;
      nf_r        <= nf_nxt;
      inited_r    <= inited_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r    <= op_nxt;
    len_r   <= len_nxt;
    start_r <= start_nxt;
    pos_r   <= pos_nxt;
    lim_r   <= lim_nxt;
    run_r   <= run_nxt;
    bot_r   <= bot_nxt;
    phase_r <= phase_nxt;
    w_r     <= w_nxt;
    wend_r  <= wend_nxt;
    first_r <= first_nxt;
    last_r  <= last_nxt;
    out_r   <= out_nxt;
  end

  // map is all clear until the first init writes every word
  assign word_eff = inited_r ? rdata_r : '0;
  assign wbase = {w_r, WB_LG'(0)};

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      mask[j]      = ((wbase + IDX_W'(j)) >= first_r) && ((wbase + IDX_W'(j)) <= last_r);
      init_word[j] = (wbase + IDX_W'(j)) < rb_r;
    end
  end

  assign bad_cfg = (bc_r < CNT_W'(2)) || (bc_r > CNT_W'(MAX_BLOCKS)) ||
                   (rb_r == '0) || ({1'b0, rb_r} >= bc_r);
  assign scan_s  = ({1'b0, nf_r} < bc_r) ? nf_r : '0;

  assign sreq = '{pos: pos_r, lim: lim_r, asc: (op_r != MODE_HIGH), len: len_r,
                  run: run_r, bot: bot_r};

  always_comb begin
    if (op_r != MODE_HIGH) begin
      pos_adv  = {pos_r[CNT_W-1:SCAN_LG] + 1'b1, SCAN_LG'(0)};
      scan_end = (pos_adv >= lim_r);
    end else begin
      pos_adv  = {pos_r[CNT_W-1:SCAN_LG], SCAN_LG'(0)} - 1'b1;
      scan_end = (pos_r[CNT_W-1:SCAN_LG] == '0);
    end
  end

  assign sum_fl = {1'b0, first_r} + len_r;

  always_comb begin
    st_nxt        = st_r;
    op_nxt        = op_r;
    len_nxt       = len_r;
    start_nxt     = start_r;
    pos_nxt       = pos_r;
    lim_nxt       = lim_r;
    run_nxt       = run_r;
    bot_nxt       = bot_r;
    phase_nxt     = phase_r;
    w_nxt         = w_r;
    wend_nxt      = wend_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    free_nxt      = free_r;
    nf_nxt        = nf_r;
    inited_nxt    = inited_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = w_r;
    wr_en         = 1'b0;
    wr_addr       = w_r;
    wr_data       = init_word;
    case (st_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_data.mode;
          len_nxt   = in_data.run_length;
          start_nxt = in_data.start_block;
          out_nxt   = '{status: ST_OK,
                        block_index: (in_data.mode == MODE_FREE) ? in_data.start_block : '0,
                        free_count: free_r};
          if (bad_cfg) begin
            out_nxt.status = ST_BAD_CFG;
            out_valid_nxt  = 1'b1;
          end else if (in_data.mode == MODE_INIT) begin
            w_nxt  = '0;
            st_nxt = S_INIT;
          end else if (in_data.run_length == '0) begin
            out_nxt.status = ST_ZERO_LEN;
            out_valid_nxt  = 1'b1;
          end else if (in_data.mode == MODE_FREE) begin
            if (({1'b0, in_data.start_block} >= bc_r) ||
                (in_data.run_length > bc_r - {1'b0, in_data.start_block})) begin
              out_nxt.status = ST_RANGE;
              out_valid_nxt  = 1'b1;
            end else begin
              first_nxt = in_data.start_block;
              last_nxt  = in_data.start_block + in_data.run_length[IDX_W-1:0] - 1'b1;
              w_nxt     = in_data.start_block[IDX_W-1:WB_LG];
              wend_nxt  = last_nxt[IDX_W-1:WB_LG];
              st_nxt    = S_CK_RD;
            end
          end else if (in_data.run_length > free_r) begin
            out_nxt.status = ST_FEW_FREE;
            out_valid_nxt  = 1'b1;
          end else begin
            run_nxt   = '0;
            bot_nxt   = '0;
            phase_nxt = 1'b0;
            if (in_data.mode == MODE_LOW) begin
              pos_nxt = {1'b0, scan_s};
              lim_nxt = bc_r;
            end else begin
              pos_nxt = bc_r - 1'b1;
              lim_nxt = bc_r;
            end
            st_nxt = S_SC_RD;
          end
        end
      end
      S_INIT: begin
        wr_en = 1'b1;
        w_nxt = w_r + 1'b1;
        if (&w_r) begin
          inited_nxt        = 1'b1;
          free_nxt          = bc_r - {1'b0, rb_r};
          nf_nxt            = rb_r;
          out_nxt.free_count = bc_r - {1'b0, rb_r};
          out_valid_nxt     = 1'b1;
          st_nxt            = S_IDLE;
        end
      end
      S_SC_RD: begin
        rd_en   = 1'b1;
        rd_addr = pos_r[IDX_W-1:WB_LG];
        st_nxt  = S_SC_CHK;
      end
      S_SC_CHK: begin
        run_nxt = srsp.run;
        bot_nxt = srsp.bot;
        if (srsp.found) begin
          first_nxt = srsp.first;
          last_nxt  = srsp.first + len_r[IDX_W-1:0] - 1'b1;
          w_nxt     = srsp.first[IDX_W-1:WB_LG];
          wend_nxt  = last_nxt[IDX_W-1:WB_LG];
          st_nxt    = S_WR_RD;
        end else if (scan_end) begin
          if (op_r == MODE_LOW && !phase_r && lim_r != {1'b0, scan_s} && scan_s != '0) begin
            phase_nxt = 1'b1;
            pos_nxt   = '0;
            lim_nxt   = {1'b0, scan_s};
            run_nxt   = '0;
            st_nxt    = S_SC_RD;
          end else begin
            out_nxt.status = ST_NO_FIT;
            out_valid_nxt  = 1'b1;
            st_nxt         = S_IDLE;
          end
        end else begin
          pos_nxt = pos_adv;
          if (pos_adv[CNT_W-1:WB_LG] != pos_r[CNT_W-1:WB_LG]) begin
            st_nxt = S_SC_RD;
          end
        end
      end
      S_CK_RD: begin
        rd_en  = 1'b1;
        st_nxt = S_CK_CMP;
      end
      S_CK_CMP: begin
        if ((word_eff & mask) != mask) begin
          out_nxt.status = ST_DBL_FREE;
          out_valid_nxt  = 1'b1;
          st_nxt         = S_IDLE;
        end else if (w_r == wend_r) begin
          w_nxt  = first_r[IDX_W-1:WB_LG];
          st_nxt = S_WR_RD;
        end else begin
          w_nxt  = w_r + 1'b1;
          st_nxt = S_CK_RD;
        end
      end
      S_WR_RD: begin
        rd_en  = 1'b1;
        st_nxt = S_WR_WR;
      end
      S_WR_WR: begin
        wr_en   = 1'b1;
        wr_data = (op_r == MODE_FREE) ? (word_eff & ~mask) : (word_eff | mask);
        w_nxt   = w_r + 1'b1;
        st_nxt  = S_WR_RD;
        if (w_r == wend_r) begin
          st_nxt        = S_IDLE;
          out_valid_nxt = 1'b1;
          if (op_r == MODE_FREE) begin
            if (start_r < nf_r) begin
              nf_nxt = start_r;
            end
            if ((free_r >= bc_r) || (len_r > bc_r - free_r)) begin
              free_nxt = bc_r;
            end else begin
              free_nxt = free_r + len_r;
            end
          end else begin
            free_nxt            = free_r - len_r;
            out_nxt.block_index = first_r;
            if (op_r == MODE_LOW) begin
              nf_nxt = (sum_fl >= bc_r) ? '0 : sum_fl[IDX_W-1:0];
            end
          end
          out_nxt.free_count = free_nxt;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  assign busy      = (st_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `include "assert_macros.svh"

  `CHK_IMPL(a_wr_state, wr_en, (st_r == S_INIT) || (st_r == S_WR_WR), "map write outside write states")
  `CHK_IMPL(a_free_cap, 1'b1, free_r <= CNT_W'(MAX_BLOCKS), "free count above capacity")
  `CHK_NEXT(a_done_idle, out_valid_nxt, !busy, "result without return to idle")
  `CHK_IMPL(a_rd_wr_excl, rd_en, !wr_en, "map read and write in one cycle")
endmodule

FILE: tb/tb_bitmap_block_allocator.sv
module tb_bitmap_block_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam int STALL_LIMIT = 20000;

  class alloc_scoreboard;
    bit          used[MAX_BLOCKS];
    int unsigned free_cnt = 0;
    int unsigned next_fit = 0;
    int unsigned blk_total = 4096;
    int unsigned reserved = 1;
    out_t        pending[$];
    int          errors = 0;

    function void write_reg(reg_idx_t idx, int unsigned val);
      if (idx == REG_BLOCK_COUNT) blk_total = val & 13'h1fff;
      else reserved = val & 12'hfff;
    endfunction

    function bit scan_up(int unsigned len, int unsigned lo, int unsigned hi,
                         output int unsigned first);
      int unsigned run;
      int unsigned bot;
      run = 0;
      bot = 0;
      first = 0;
      for (int unsigned b = lo; b < hi; b++) begin
        if (used[b]) begin
          run = 0;
          continue;
        end
        if (run == 0) bot = b;
        run++;
        if (run == len) begin
          first = bot;
          return 1;
        end
      end
      return 0;
    endfunction

    function bit scan_down(int unsigned len, output int unsigned first);
      int unsigned run;
      run = 0;
      first = 0;
      for (int unsigned b = blk_total; b > 0; b--) begin
        if (used[b-1]) begin
          run = 0;
          continue;
        end
        run++;
        if (run == len) begin
          first = b - 1;
          return 1;
        end
      end
      return 0;
    endfunction

    function out_t note(in_t w);
      out_t        e;
      int unsigned len, st, first, s;
      bit          ok;
      len = w.run_length;
      st = w.start_block;
      e.status = ST_OK;
      e.block_index = (w.mode == MODE_FREE) ? w.start_block : '0;
      if (blk_total < 2 || blk_total > MAX_BLOCKS || reserved == 0 ||
          reserved >= blk_total) begin
        e.status = ST_BAD_CFG;
      end else if (w.mode == MODE_INIT) begin
        for (int i = 0; i < MAX_BLOCKS; i++) used[i] = (i < reserved);
        free_cnt = blk_total - reserved;
        next_fit = reserved;
      end else if (len == 0) begin
        e.status = ST_ZERO_LEN;
      end else if (w.mode != MODE_FREE) begin
        if (len > free_cnt) begin
          e.status = ST_FEW_FREE;
        end else begin
          if (w.mode == MODE_LOW) begin
            s = (next_fit < blk_total) ? next_fit : 0;
            ok = scan_up(len, s, blk_total, first);
            if (!ok && s != 0) ok = scan_up(len, 0, s, first);
          end else begin
            ok = scan_down(len, first);
          end
          if (!ok) begin
            e.status = ST_NO_FIT;
          end else begin
            for (int unsigned i = 0; i < len; i++) used[first+i] = 1;
            if (w.mode == MODE_LOW) begin
              next_fit = first + len;
              if (next_fit >= blk_total) next_fit = 0;
            end
            free_cnt -= len;
            e.block_index = IDX_W'(first);
          end
        end
      end else begin
        if (st >= blk_total || len > blk_total - st) begin
          e.status = ST_RANGE;
        end else begin
          for (int unsigned i = 0; i < len; i++)
            if (!used[st+i]) e.status = ST_DBL_FREE;
          if (e.status == ST_OK) begin
            for (int unsigned i = 0; i < len; i++) used[st+i] = 0;
            if (st < next_fit) next_fit = st;
            if (free_cnt >= blk_total || len > blk_total - free_cnt)
              free_cnt = blk_total;
            else
              free_cnt += len;
          end
        end
      end
      e.free_count = CNT_W'(free_cnt);
      pending.push_back(e);
      return e;
    endfunction

    function void check(out_t got);
      out_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word, actual %p", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status || got.block_index !== e.block_index ||
          got.free_count !== e.free_count) begin
        $display("%0t: mismatch, expected %p, actual %p", $time, e, got);
        errors++;
      end
    endfunction
  endclass

  typedef struct {
    int unsigned first;
    int unsigned len;
  } run_t;

  logic                 clk = 0;
  logic                 rst_n = 0;
  logic                 start = 0;
  logic                 busy;
  in_t                  in_data = '0;
  logic                 out_valid;
  out_t                 out_data;
  logic                 cfg_we = 0;
  reg_idx_t             cfg_idx = REG_BLOCK_COUNT;
  logic [CNT_W-1:0]     cfg_wdata = '0;

  alloc_scoreboard sb = new();
  run_t            live_runs[$];
  bit              idling = 1;
  int              quiet = 0;

  bitmap_block_allocator i_dut (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .cfg_we, .cfg_idx, .cfg_wdata
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check(out_data);
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("bitmap_block_allocator verification failed");
      $finish;
    end
  end

  task automatic issue(mode_t mode, int unsigned first, int unsigned len);
    in_t  w;
    out_t e;
    if (idling && $urandom_range(99) < 11) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    w.mode = mode;
    w.start_block = IDX_W'(first);
    w.run_length = CNT_W'(len);
    in_data <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    e = sb.note(w);
    if (e.status == ST_OK) begin
      if (mode == MODE_INIT) live_runs.delete();
      else if (mode != MODE_FREE) live_runs.push_back('{e.block_index, len});
    end
  endtask

  task automatic set_reg(reg_idx_t idx, int unsigned val);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= CNT_W'(val);
    sb.write_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_word(int unsigned bc);
    int unsigned r, k, len;
    r = $urandom_range(99);
    len = ($urandom_range(99) < 80) ? $urandom_range(1, 8) : $urandom_range(1, bc);
    if (r < 38) begin
      issue(MODE_LOW, $urandom_range(4095), len);
    end else if (r < 62) begin
      issue(MODE_HIGH, $urandom_range(4095), len);
    end else if (r < 90 && live_runs.size() != 0) begin
      k = $urandom_range(live_runs.size() - 1);
      len = live_runs[k].len;
      if ($urandom_range(9) == 0) len = $urandom_range(1, len + 1);
      issue(MODE_FREE, live_runs[k].first, len);
      live_runs.delete(k);
    end else begin
      issue(mode_t'($urandom_range(3)), $urandom_range(4095), $urandom_range(8191));
    end
  endtask

  initial begin
    static int unsigned bcs[12] = '{64, 2, 200, 4096, 64, 130, 4096, 1000, 1, 5000, 64, 64};
    static int unsigned rbs[12] = '{1, 1, 17, 4095, 63, 5, 1, 300, 1, 3, 0, 64};
    int unsigned n;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default config, first before init and then after it
    issue(MODE_LOW, 0, 1);
    issue(MODE_FREE, 0, 1);
    issue(MODE_INIT, 4095, 8191);
    issue(MODE_LOW, 0, 0);
    issue(MODE_FREE, 5, 0);
    issue(MODE_LOW, 0, 4096);
    issue(MODE_HIGH, 0, 4095);
    issue(MODE_LOW, 0, 1);
    issue(MODE_FREE, 1, 4095);
    issue(MODE_FREE, 4095, 2);
    issue(MODE_FREE, 4095, 1);
    issue(MODE_HIGH, 0, 1);
    issue(MODE_LOW, 0, 5);
    issue(MODE_FREE, 4095, 1);
    // free count saturates after the block count shrinks
    set_reg(REG_BLOCK_COUNT, 200);
    set_reg(REG_RESERVED, 17);
    issue(MODE_INIT, 0, 0);
    issue(MODE_LOW, 0, 10);
    issue(MODE_HIGH, 0, 3);
    set_reg(REG_BLOCK_COUNT, 20);
    issue(MODE_FREE, 17, 3);
    issue(MODE_LOW, 0, 3);
    issue(MODE_FREE, 19, 2);

    for (int p = 0; p < 12; p++) begin
      set_reg(REG_BLOCK_COUNT, bcs[p]);
      set_reg(REG_RESERVED, rbs[p]);
      issue(MODE_INIT, 0, 0);
      n = (p >= 8) ? 6 : 80;
      for (int i = 0; i < n; i++) begin
        idling = !(p == 4);
        random_word((bcs[p] >= 2 && bcs[p] <= 4096) ? bcs[p] : 64);
      end
      idling = 1;
    end

    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("bitmap_block_allocator verification clean");
    else
      $display("bitmap_block_allocator verification failed");
    $finish;
  end
endmodule
